/* hw/rtl/tlge_pkg.sv */
// Shared types and constants for the toroidal Life generation engine.
// No dependencies; imported by the top level, tlge_ctrl, tlge_cell_unit and the bench.
`timescale 1ns / 1ps

package tlge_pkg;

    // Command codes carried in the request
    typedef enum logic [2:0] {
        CMD_SET    = 3'd0,
        CMD_KILL   = 3'd1,
        CMD_TOGGLE = 3'd2,
        CMD_READ   = 3'd3,
        CMD_STEP   = 3'd4,
        CMD_CLEAR  = 3'd5
    } tlge_cmd_t;

    // Configuration register indexes
    localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_SURVIVE_LOW  = 2'd2;
    localparam logic [1:0] REG_SURVIVE_HIGH = 2'd3;

    localparam int MIN_SIZE = 3;

    typedef enum logic [3:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_MOD,
        ST_CLR,
        ST_GEN_RD_LAST,
        ST_GEN_RD0,
        ST_GEN_CAP0,
        ST_GEN_RD,
        ST_GEN_NEXT,
        ST_GEN_CELL,
        ST_GEN_WR,
        ST_DONE
    } tlge_state_t;

    typedef struct packed {
        logic [3:0] survive_low;
        logic [3:0] survive_high;
    } tlge_rule_t;

    typedef struct packed {
        logic bad_coord;
        logic changed;
        logic cell_value;
    } tlge_result_t;

endpackage

/* hw/rtl/toroidal_life_generation_engine_top.sv */
// Top level of the toroidal Life generation engine: configuration registers,
// size clamping, result register. Depends on tlge_pkg, tlge_grid_mem, tlge_ctrl.
`timescale 1ns / 1ps
//
// Requests enter on s_tvalid/s_tready/s_tdata (cmd, col, row); each request
// gives exactly one result on m_tvalid/m_tready/m_tdata. Registers are written
// over cfg_valid/cfg_ready/cfg_index/cfg_data; the user must write them only
// while idle, as the block does not enforce it; cfg_ready is always high.
// The grid is held one row per memory word. A step slides a three-row window
// down the grid and feeds one cell per cycle through the shared rule unit.
// Cell commands read the row, then modify-write it, then give the result; a
// clear writes zero to every row of the memory, and unused commands go straight
// to the result. One request is in work at a time; s_tready is high only while
// the sequencer is idle.
// After reset the grid is swept clear, one row per cycle, with s_tready low;
// registers return to 64, 64, 2, 3.
// A finished result sits in the output register; while the receiver stalls
// the block can take the next request but holds its own result until the
// register is free.

module toroidal_life_generation_engine_top #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // cmd[2:0], col[8:3], row[14:9], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // cell_value[0], changed[1], bad_coord[2], zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import tlge_pkg::*;

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WS0 = $clog2(MAX_WIDTH + 1);
    localparam int HS0 = $clog2(MAX_HEIGHT + 1);
    localparam int WS  = (WS0 > 7) ? WS0 : 7;
    localparam int HS  = (HS0 > 7) ? HS0 : 7;

    logic [6:0] grid_width_reg, grid_height_reg;
    logic [3:0] survive_low_reg, survive_high_reg;

    logic [WS-1:0] gw, w_eff;
    logic [HS-1:0] gh, h_eff;
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;
    tlge_rule_t    rule;

    tlge_result_t  result;
    logic          res_valid, res_take;
    logic          m_tvalid_reg;
    tlge_result_t  out_reg;

    logic                 mem_rd_en, mem_wr_en;
    logic [RW-1:0]        mem_rd_addr, mem_wr_addr;
    logic [MAX_WIDTH-1:0] mem_rd_data, mem_wr_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg   <= 7'd64;
            grid_height_reg  <= 7'd64;
            survive_low_reg  <= 4'd2;
            survive_high_reg <= 4'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:   grid_width_reg   <= cfg_data;
                REG_GRID_HEIGHT:  grid_height_reg  <= cfg_data;
                REG_SURVIVE_LOW:  survive_low_reg  <= cfg_data[3:0];
                REG_SURVIVE_HIGH: survive_high_reg <= cfg_data[3:0];
                default:          survive_high_reg <= survive_high_reg;
            endcase
        end
    end

    // sizes below three or above the grid limits are clamped
    assign gw = WS'(grid_width_reg);
    assign gh = HS'(grid_height_reg);

    always_comb
    begin
        if (gw < WS'(MIN_SIZE))
        begin
            w_eff = WS'(MIN_SIZE);
        end
        else if (gw > WS'(MAX_WIDTH))
        begin
            w_eff = WS'(MAX_WIDTH);
        end
        else
        begin
            w_eff = gw;
        end
        if (gh < HS'(MIN_SIZE))
        begin
            h_eff = HS'(MIN_SIZE);
        end
        else if (gh > HS'(MAX_HEIGHT))
        begin
            h_eff = HS'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = gh;
        end
    end

    assign w_last = CW'(w_eff - 1'b1);
    assign h_last = RW'(h_eff - 1'b1);

    assign rule.survive_low  = survive_low_reg;
    assign rule.survive_high = survive_high_reg;

    tlge_grid_mem #(
        .ROW_BITS (MAX_WIDTH),
        .ROWS     (MAX_HEIGHT),
        .AW       (RW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    tlge_ctrl #(
        .ROW_BITS (MAX_WIDTH),
        .ROWS     (MAX_HEIGHT),
        .CW       (CW),
        .RW       (RW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tdata[2:0]),
        .in_col      (s_tdata[8:3]),
        .in_row      (s_tdata[14:9]),
        .w_last      (w_last),
        .h_last      (h_last),
        .rule        (rule),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .result      (result),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    assign res_take = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_reg.bad_coord, out_reg.changed, out_reg.cell_value};

endmodule

/* hw/rtl/tlge_grid_mem.sv */
// Cell grid storage: one row of the grid per word, one write and one read port.
// Read data is registered. Depends on nothing.
`timescale 1ns / 1ps

module tlge_grid_mem #(
    parameter int ROW_BITS = 64,
    parameter int ROWS     = 64,
    parameter int AW       = 6
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic [ROW_BITS-1:0] rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [ROW_BITS-1:0] wr_data
);

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/tlge_cell_unit.sv */
// Shared rule unit: counts the eight neighbours of one cell and applies the
// survival and birth rule. Depends on tlge_pkg.
`timescale 1ns / 1ps

module tlge_cell_unit (
    input  logic [2:0]          above,
    input  logic [2:0]          middle,   // bit 1 is the cell itself
    input  logic [2:0]          below,
    input  tlge_pkg::tlge_rule_t rule,
    output logic                alive_next,
    output logic                flip
);
    import tlge_pkg::*;

    logic [3:0] count;

    assign count = {3'b0, above[0]} + {3'b0, above[1]} + {3'b0, above[2]}
                 + {3'b0, middle[0]} + {3'b0, middle[2]}
                 + {3'b0, below[0]} + {3'b0, below[1]} + {3'b0, below[2]};

    always_comb
    begin
        if (middle[1])
        begin
            alive_next = (count >= rule.survive_low) && (count <= rule.survive_high);
        end
        else
        begin
            alive_next = (count == rule.survive_high);
        end
    end

    assign flip = alive_next ^ middle[1];

endmodule

/* hw/rtl/tlge_ctrl.sv */
// Sequencer: decodes requests, runs cell read-modify-writes, grid clears and
// the row-window generation sweep through the shared rule unit.
// Depends on tlge_pkg and tlge_cell_unit.
`timescale 1ns / 1ps

module tlge_ctrl #(
    parameter int ROW_BITS = 64,
    parameter int ROWS     = 64,
    parameter int CW       = 6,
    parameter int RW       = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             in_cmd,
    input  logic [5:0]             in_col,
    input  logic [5:0]             in_row,
    input  logic [CW-1:0]          w_last,
    input  logic [RW-1:0]          h_last,
    input  tlge_pkg::tlge_rule_t   rule,
    output logic                   res_valid,
    input  logic                   res_take,
    output tlge_pkg::tlge_result_t result,
    output logic                   mem_rd_en,
    output logic [RW-1:0]          mem_rd_addr,
    input  logic [ROW_BITS-1:0]    mem_rd_data,
    output logic                   mem_wr_en,
    output logic [RW-1:0]          mem_wr_addr,
    output logic [ROW_BITS-1:0]    mem_wr_data
);
    import tlge_pkg::*;

    localparam int XW = (CW > 6) ? CW : 6;
    localparam int YW = (RW > 6) ? RW : 6;

    tlge_state_t state_reg, state_next;

    logic [ROW_BITS-1:0] prev_reg, prev_next;
    logic [ROW_BITS-1:0] cur_reg, cur_next;
    logic [ROW_BITS-1:0] below_reg, below_next;
    logic [ROW_BITS-1:0] row0_reg, row0_next;
    logic [ROW_BITS-1:0] new_reg, new_next;
    logic [CW-1:0]       c_reg, c_next;
    logic [RW-1:0]       r_reg, r_next;
    logic                any_reg, any_next;
    tlge_cmd_t           cmd_reg, cmd_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    tlge_result_t        res_reg, res_next;

    logic [XW-1:0] col_x;
    logic [YW-1:0] row_x;
    logic          bad_in;
    logic          accept;

    logic [CW-1:0] cp, cn;
    logic [2:0]    nb_above, nb_middle, nb_below;
    logic          alive_next, flip;

    logic                old_bit, new_bit;
    logic [ROW_BITS-1:0] mod_row;

    assign col_x  = XW'(in_col);
    assign row_x  = YW'(in_row);
    assign bad_in = (col_x > XW'(w_last)) || (row_x > YW'(h_last));
    assign accept = in_valid && in_ready;

    // wrapped neighbour columns
    assign cp = (c_reg == '0) ? w_last : c_reg - 1'b1;
    assign cn = (c_reg == w_last) ? '0 : c_reg + 1'b1;

    assign nb_above  = {prev_reg[cn], prev_reg[c_reg], prev_reg[cp]};
    assign nb_middle = {cur_reg[cn], cur_reg[c_reg], cur_reg[cp]};
    assign nb_below  = {below_reg[cn], below_reg[c_reg], below_reg[cp]};

    tlge_cell_unit u_cell (
        .above      (nb_above),
        .middle     (nb_middle),
        .below      (nb_below),
        .rule       (rule),
        .alive_next (alive_next),
        .flip       (flip)
    );

    // cell command: modify one bit of the row just read
    always_comb
    begin
        old_bit = mem_rd_data[col_reg];
        case (cmd_reg)
            CMD_SET:    new_bit = 1'b1;
            CMD_KILL:   new_bit = 1'b0;
            CMD_TOGGLE: new_bit = ~old_bit;
            default:    new_bit = old_bit;
        endcase
        mod_row          = mem_rd_data;
        mod_row[col_reg] = new_bit;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT_CLR:
            begin
                if (r_reg == RW'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (tlge_cmd_t'(in_cmd))
                        CMD_SET, CMD_KILL, CMD_TOGGLE, CMD_READ:
                            state_next = bad_in ? ST_DONE : ST_CELL_RD;
                        CMD_STEP:  state_next = ST_GEN_RD_LAST;
                        CMD_CLEAR: state_next = ST_CLR;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_CELL_RD:     state_next = ST_CELL_MOD;
            ST_CELL_MOD:    state_next = ST_DONE;
            ST_CLR:
            begin
                if (r_reg == RW'(ROWS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_GEN_RD_LAST: state_next = ST_GEN_RD0;
            ST_GEN_RD0:     state_next = ST_GEN_CAP0;
            ST_GEN_CAP0:    state_next = ST_GEN_RD;
            ST_GEN_RD:      state_next = ST_GEN_NEXT;
            ST_GEN_NEXT:    state_next = ST_GEN_CELL;
            ST_GEN_CELL:
            begin
                if (c_reg == w_last)
                begin
                    state_next = ST_GEN_WR;
                end
            end
            ST_GEN_WR:      state_next = (r_reg == h_last) ? ST_DONE : ST_GEN_RD;
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // outputs: handshake and memory ports
    always_comb
    begin
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_reg;
        mem_wr_data = '0;
        case (state_reg)
            ST_INIT_CLR, ST_CLR:
            begin
                mem_wr_en = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_CELL_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = row_reg;
            end
            ST_CELL_MOD:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = row_reg;
                mem_wr_data = mod_row;
            end
            ST_GEN_RD_LAST:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = h_last;
            end
            ST_GEN_RD0:
            begin
                mem_rd_en = 1'b1;
            end
            ST_GEN_RD:
            begin
                // last row takes the saved original row 0 instead
                mem_rd_en   = (r_reg != h_last);
                mem_rd_addr = r_reg + 1'b1;
            end
            ST_GEN_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = new_reg;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        below_next = below_reg;
        row0_next  = row0_reg;
        new_next   = new_reg;
        c_next     = c_reg;
        r_next     = r_reg;
        any_next   = any_reg;
        cmd_next   = cmd_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        res_next   = res_reg;
        case (state_reg)
            ST_INIT_CLR, ST_CLR:
            begin
                r_next = r_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = tlge_cmd_t'(in_cmd);
                    col_next = col_x[CW-1:0];
                    row_next = row_x[RW-1:0];
                    r_next   = '0;
                    any_next = 1'b0;
                    res_next = '0;
                    if ((in_cmd <= 3'(CMD_READ)) && bad_in)
                    begin
                        res_next.bad_coord = 1'b1;
                    end
                end
            end
            ST_CELL_MOD:
            begin
                res_next.cell_value = new_bit;
            end
            ST_GEN_RD0:
            begin
                prev_next = mem_rd_data;
            end
            ST_GEN_CAP0:
            begin
                cur_next  = mem_rd_data;
                row0_next = mem_rd_data;
            end
            ST_GEN_NEXT:
            begin
                below_next = (r_reg == h_last) ? row0_reg : mem_rd_data;
                new_next   = cur_reg;
                c_next     = '0;
            end
            ST_GEN_CELL:
            begin
                new_next[c_reg] = alive_next;
                any_next        = any_reg | flip;
                c_next          = c_reg + 1'b1;
            end
            ST_GEN_WR:
            begin
                prev_next = cur_reg;
                cur_next  = below_reg;
                r_next    = r_reg + 1'b1;
                res_next.changed = any_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT_CLR;
            r_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        below_reg <= below_next;
        row0_reg  <= row0_next;
        new_reg   <= new_next;
        c_reg     <= c_next;
        any_reg   <= any_next;
        cmd_reg   <= cmd_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        res_reg   <= res_next;
    end

    assign result = res_reg;

endmodule

/* tb/tb.sv */
// Self-checking bench for toroidal_life_generation_engine_top: a directed table, then
// random phases of cell, step, clear and unused-code requests, checked against an in-bench board model.
// Depends on tlge_pkg and the top level only.
`timescale 1ns / 1ps

module tb;

    import tlge_pkg::*;

    localparam int GRID_W       = 64;
    localparam int GRID_H       = 64;
    localparam int RANDOM_ITEMS = 110;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 50;

    // codes the package leaves unnamed; the block answers them with all zeros
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    localparam tlge_result_t RES_NONE  = 3'b000;
    localparam tlge_result_t RES_ALIVE = 3'b001;
    localparam tlge_result_t RES_BAD   = 3'b100;

    typedef struct {
        bit           is_reg;
        logic [1:0]   reg_idx;
        logic [6:0]   reg_val;
        logic [2:0]   cmd;
        logic [5:0]   col;
        logic [5:0]   row;
        bit           known;
        tlge_result_t res;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;      // cmd[2:0], col[8:3], row[14:9], zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [7:0]  m_tdata;           // cell_value[0], changed[1], bad_coord[2], zero fill
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;

    // board model and its copy of the registers
    bit          board [GRID_H][GRID_W];
    bit          scratch [GRID_H][GRID_W];
    bit [6:0]    cols_reg = 7'd64;
    bit [6:0]    rows_reg = 7'd64;
    bit [3:0]    live_min = 4'd2;
    bit [3:0]    live_max = 4'd3;

    tlge_result_t results_due [$];
    plan_row_t    opening_plan [$];
    int           faults = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;
    bit           no_gaps = 1'b0;

    toroidal_life_generation_engine_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void note_fault(input string msg);
        faults++;
        if (faults <= 10)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endfunction

    function automatic int span(input bit [6:0] v, input int limit);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // Applies one request to the board model and returns the answer it should get.
    function automatic tlge_result_t life_apply(input logic [2:0] cmd, input logic [5:0] col,
                                                input logic [5:0] row);
        tlge_result_t res;
        int  w, h, n, r, c, dr, dc;
        bit  grow, any;
        res = RES_NONE;
        w = span(cols_reg, GRID_W);
        h = span(rows_reg, GRID_H);
        case (cmd)
            CMD_SET, CMD_KILL, CMD_TOGGLE, CMD_READ:
            begin
                if (col >= w || row >= h)
                    res.bad_coord = 1'b1;
                else
                begin
                    if (cmd == CMD_SET)
                        board[row][col] = 1'b1;
                    else if (cmd == CMD_KILL)
                        board[row][col] = 1'b0;
                    else if (cmd == CMD_TOGGLE)
                        board[row][col] = !board[row][col];
                    res.cell_value = board[row][col];
                end
            end
            CMD_STEP:
            begin
                any = 1'b0;
                for (r = 0; r < h; r++)
                    for (c = 0; c < w; c++)
                    begin
                        n = 0;
                        for (dr = -1; dr <= 1; dr++)
                            for (dc = -1; dc <= 1; dc++)
                                if (dr != 0 || dc != 0)
                                    n += board[(r + dr + h) % h][(c + dc + w) % w];
                        if (board[r][c])
                            grow = (n >= live_min) && (n <= live_max);
                        else
                            grow = (n == live_max);
                        scratch[r][c] = grow;
                        if (grow != board[r][c])
                            any = 1'b1;
                    end
                // cells outside the area in use are never touched
                if (any)
                    for (r = 0; r < h; r++)
                        for (c = 0; c < w; c++)
                            board[r][c] = scratch[r][c];
                res.changed = any;
            end
            CMD_CLEAR:
            begin
                for (r = 0; r < GRID_H; r++)
                    for (c = 0; c < GRID_W; c++)
                        board[r][c] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic plan_row_t ask(input logic [2:0] cmd, input logic [5:0] col,
                                      input logic [5:0] row);
        plan_row_t p;
        p = '{default: '0};
        p.cmd = cmd;
        p.col = col;
        p.row = row;
        return p;
    endfunction

    function automatic plan_row_t ask_known(input logic [2:0] cmd, input logic [5:0] col,
                                            input logic [5:0] row, input tlge_result_t res);
        plan_row_t p;
        p = ask(cmd, col, row);
        p.known = 1'b1;
        p.res = res;
        return p;
    endfunction

    function automatic plan_row_t set_reg(input logic [1:0] idx, input logic [6:0] val);
        plan_row_t p;
        p = '{default: '0};
        p.is_reg = 1'b1;
        p.reg_idx = idx;
        p.reg_val = val;
        return p;
    endfunction

    // Offers one request; s_tvalid stays high afterwards so back-to-back requests
    // never see a low/high pair in the same step.
    task automatic send_cmd(input logic [2:0] cmd, input logic [5:0] col, input logic [5:0] row,
                            input bit known, input tlge_result_t given);
        tlge_result_t predicted;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        while (!no_gaps && $urandom_range(0, 99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, row, col, cmd};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predicted = life_apply(cmd, col, row);
        results_due.push_back(known ? given : predicted);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0 || s_tready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            REG_GRID_WIDTH:   cols_reg = val;
            REG_GRID_HEIGHT:  rows_reg = val;
            REG_SURVIVE_LOW:  live_min = val[3:0];
            REG_SURVIVE_HIGH: live_max = val[3:0];
            default:          ;
        endcase
    endtask

    // result side: checks each answer against the oldest expectation
    initial
    begin : result_sink
        tlge_result_t want;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                if (results_due.size() == 0)
                    note_fault($sformatf("result %b with no request outstanding", m_tdata));
                else
                begin
                    want = results_due.pop_front();
                    if (m_tdata[0] !== want.cell_value || m_tdata[1] !== want.changed ||
                        m_tdata[2] !== want.bad_coord)
                        note_fault($sformatf(
                            "cell_value exp %b got %b, changed exp %b got %b, bad_coord exp %b got %b",
                            want.cell_value, m_tdata[0], want.changed, m_tdata[1],
                            want.bad_coord, m_tdata[2]));
                end
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= no_gaps || ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1) ||
            (cfg_valid === 1'b1 && cfg_ready === 1'b1))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int         phase, count, pick, w, h, random_done;
        logic [2:0] cmd;
        logic [5:0] col, row;
        logic [6:0] w_val, h_val, lo_val, hi_val;

        // fresh board, glider-free blinker, then the smallest torus and odd rules
        opening_plan.push_back(ask_known(CMD_READ,   6'd0,  6'd0,  RES_NONE));
        opening_plan.push_back(ask_known(CMD_READ,   6'd63, 6'd63, RES_NONE));
        opening_plan.push_back(ask_known(CMD_SET,    6'd63, 6'd63, RES_ALIVE));
        opening_plan.push_back(ask_known(CMD_SET,    6'd0,  6'd0,  RES_ALIVE));
        opening_plan.push_back(ask_known(CMD_TOGGLE, 6'd0,  6'd0,  RES_NONE));
        opening_plan.push_back(ask_known(CMD_TOGGLE, 6'd0,  6'd0,  RES_ALIVE));
        opening_plan.push_back(ask_known(CMD_KILL,   6'd0,  6'd0,  RES_NONE));
        opening_plan.push_back(ask_known(CMD_SET,    6'd1,  6'd1,  RES_ALIVE));
        opening_plan.push_back(ask_known(CMD_SET,    6'd2,  6'd1,  RES_ALIVE));
        opening_plan.push_back(ask_known(CMD_SET,    6'd3,  6'd1,  RES_ALIVE));
        opening_plan.push_back(ask(CMD_STEP, 6'd0, 6'd0));
        opening_plan.push_back(ask(CMD_READ, 6'd2, 6'd0));
        opening_plan.push_back(ask(CMD_READ, 6'd1, 6'd1));
        opening_plan.push_back(ask_known(CMD_SPARE6, 6'd63, 6'd63, RES_NONE));
        opening_plan.push_back(ask_known(CMD_SPARE7, 6'd0,  6'd0,  RES_NONE));
        opening_plan.push_back(ask_known(CMD_CLEAR,  6'd0,  6'd0,  RES_NONE));
        opening_plan.push_back(ask_known(CMD_READ,   6'd2,  6'd0,  RES_NONE));
        opening_plan.push_back(ask_known(CMD_STEP,   6'd0,  6'd0,  RES_NONE));
        opening_plan.push_back(set_reg(REG_GRID_WIDTH,  7'd3));
        opening_plan.push_back(set_reg(REG_GRID_HEIGHT, 7'd3));
        opening_plan.push_back(ask_known(CMD_READ,   6'd3,  6'd0,  RES_BAD));
        opening_plan.push_back(ask_known(CMD_SET,    6'd0,  6'd3,  RES_BAD));
        opening_plan.push_back(ask_known(CMD_TOGGLE, 6'd63, 6'd63, RES_BAD));
        opening_plan.push_back(ask_known(CMD_TOGGLE, 6'd2,  6'd2,  RES_ALIVE));
        opening_plan.push_back(ask(CMD_STEP, 6'd0, 6'd0));
        // lower bound above upper bound: nothing survives
        opening_plan.push_back(set_reg(REG_SURVIVE_LOW,  7'd15));
        opening_plan.push_back(set_reg(REG_SURVIVE_HIGH, 7'd8));
        opening_plan.push_back(ask_known(CMD_SET, 6'd1, 6'd1, RES_ALIVE));
        opening_plan.push_back(ask(CMD_STEP, 6'd0, 6'd0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening_plan[i])
        begin
            if (opening_plan[i].is_reg)
            begin
                if (i == 0 || !opening_plan[i - 1].is_reg)
                    wait_idle();
                write_reg(opening_plan[i].reg_idx, opening_plan[i].reg_val);
            end
            else
                send_cmd(opening_plan[i].cmd, opening_plan[i].col, opening_plan[i].row,
                         opening_plan[i].known, opening_plan[i].res);
        end

        phase = 0;
        random_done = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            wait_idle();
            if (phase % 5 == 3)
            begin
                // the full board, or a size beyond it that clamps back
                w_val = ($urandom_range(0, 1) != 0) ? 7'd64 : 7'($urandom_range(65, 127));
                h_val = ($urandom_range(0, 1) != 0) ? 7'd64 : 7'($urandom_range(65, 127));
            end
            else
            begin
                w_val = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 2))
                                                    : 7'($urandom_range(3, 10));
                h_val = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 2))
                                                    : 7'($urandom_range(3, 10));
            end
            lo_val = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(1, 3));
            hi_val = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(3, 4));
            write_reg(REG_GRID_WIDTH, w_val);
            write_reg(REG_GRID_HEIGHT, h_val);
            write_reg(REG_SURVIVE_LOW, lo_val);
            write_reg(REG_SURVIVE_HIGH, hi_val);
            w = span(cols_reg, GRID_W);
            h = span(rows_reg, GRID_H);
            no_gaps = (phase == 2);
            count = (phase == 2) ? 40 : $urandom_range(12, 24);

            if (phase == 1)
            begin
                // sink holds off while requests keep coming, so the input backs up
                hold_left = HOLD_CYCLES;
                repeat (10)
                begin
                    send_cmd(($urandom_range(0, 1) != 0) ? CMD_SET : CMD_READ,
                             6'($urandom_range(0, w - 1)), 6'($urandom_range(0, h - 1)),
                             1'b0, RES_NONE);
                    random_done++;
                end
            end

            repeat (count)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    cmd = CMD_SET;
                else if (pick < 45)
                    cmd = CMD_TOGGLE;
                else if (pick < 55)
                    cmd = CMD_KILL;
                else if (pick < 72)
                    cmd = CMD_READ;
                else if (pick < 90)
                    cmd = CMD_STEP;
                else if (pick < 94)
                    cmd = CMD_CLEAR;
                else if (pick < 97)
                    cmd = CMD_SPARE6;
                else
                    cmd = CMD_SPARE7;
                if ($urandom_range(0, 99) < 85)
                begin
                    col = 6'($urandom_range(0, w - 1));
                    row = 6'($urandom_range(0, h - 1));
                end
                else
                begin
                    col = 6'($urandom_range(0, 63));
                    row = 6'($urandom_range(0, 63));
                end
                send_cmd(cmd, col, row, 1'b0, RES_NONE);
                random_done++;
            end
            phase++;
        end

        no_gaps = 1'b0;
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (faults == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* toroidal_life_generation_engine_top.f */
hw/rtl/tlge_pkg.sv
hw/rtl/tlge_grid_mem.sv
hw/rtl/tlge_cell_unit.sv
hw/rtl/tlge_ctrl.sv
hw/rtl/toroidal_life_generation_engine_top.sv
tb/tb.sv
